### rtl/core/ssbd_pkg.sv
// ----------------------------------------------------------------------------
// ssbd_pkg
// Shared types and constants of the phasing SSB demodulator: filter depth,
// field widths, opcodes and the control group that drives each filter lane.
// ----------------------------------------------------------------------------
package ssbd_pkg;

  localparam int TAP_COUNT  = 128;
  localparam int TAP_W      = $clog2(TAP_COUNT);
  localparam int FILL_W     = $clog2(TAP_COUNT + 1);

  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 24;
  localparam int CTAP_W     = 7;
  localparam int OUT_W      = 32;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_W + 1;
  localparam int SUM_W      = ACC_W + 1;

  // (sum * 8) / 2^23 is the sum scaled down by 2^20
  localparam int FRAC_SHIFT = 20;
  localparam int ROUND_BIAS = (1 << FRAC_SHIFT) - 1;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_COEF    = 1'b1;
  localparam logic BANK_MINUS = 1'b0;
  localparam logic BANK_PLUS  = 1'b1;
  localparam logic SB_USB     = 1'b0;
  localparam logic SB_LSB     = 1'b1;

  typedef struct packed {
    logic acc_clr;  // start a new sum
    logic mul_en;   // history and coefficient words are on the read ports
    logic mul_ok;   // that history entry holds a sample since the last clear
    logic acc_en;   // product register holds a term to add
  } ssbd_lane_ctl_t;

endpackage

### rtl/core/ssbd_ram.sv
// ----------------------------------------------------------------------------
// ssbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ssbd_lane.sv
// ----------------------------------------------------------------------------
// ssbd_lane
// One filter channel: circular history memory, registered multiplier and
// multiply-accumulate register, one tap per cycle.
// ----------------------------------------------------------------------------
module ssbd_lane (
  input  logic                                clk,
  input  logic                                hist_we,
  input  logic [ssbd_pkg::TAP_W-1:0]          hist_waddr,
  input  logic [ssbd_pkg::SAMPLE_W-1:0]       hist_wdata,
  input  logic [ssbd_pkg::TAP_W-1:0]          hist_raddr,
  input  logic [ssbd_pkg::COEF_W-1:0]         coef,
  input  ssbd_pkg::ssbd_lane_ctl_t            ctl,
  output logic signed [ssbd_pkg::ACC_W-1:0]   acc
);
  import ssbd_pkg::*;

  logic [SAMPLE_W-1:0]      hist_q;
  logic signed [PROD_W-1:0] product_r;
  logic signed [ACC_W-1:0]  acc_r;

  ssbd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAP_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      if (ctl.mul_ok) begin
        product_r <= $signed(hist_q) * $signed(coef);
      end else begin
        // drop entries older than the last clear
        product_r <= '0;
      end
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(product_r);
    end
  end

  assign acc = acc_r;

endmodule

### rtl/core/ssbd_merge.sv
// ----------------------------------------------------------------------------
// ssbd_merge
// Sum the two lane results, scale down toward zero, saturate to the slot
// word and hold it in the output register until taken.
// ----------------------------------------------------------------------------
module ssbd_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               sum_en,
  input  logic signed [ssbd_pkg::ACC_W-1:0]  acc_left,
  input  logic signed [ssbd_pkg::ACC_W-1:0]  acc_right,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ssbd_pkg::OUT_W-1:0]  out_audio_out
);
  import ssbd_pkg::*;

  logic signed [SUM_W-1:0] sum_r;
  logic                    sum_v_r;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] quot;
  logic [SUM_W-OUT_W:0]    upper;
  logic [OUT_W-1:0]        sat;
  logic                    load;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  // bias negative sums so the arithmetic shift rounds toward zero
  assign biased = sum_r + (sum_r[SUM_W-1] ? SUM_W'(ROUND_BIAS) : '0);
  assign quot   = biased >>> FRAC_SHIFT;
  assign upper  = quot[SUM_W-1:OUT_W-1];
  assign sat    = ((&upper) || !(|upper)) ? quot[OUT_W-1:0] :
                  (quot[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} :
                                   {1'b0, {(OUT_W-1){1'b1}}});
  assign load   = sum_v_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_v_r <= 1'b1;
      end else if (load) begin
        sum_v_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= SUM_W'(acc_left) + SUM_W'(acc_right);
    end
    if (load) begin
      out_data_r <= sat;
    end
  end

  assign busy          = sum_v_r;
  assign out_valid     = out_valid_r;
  assign out_audio_out = $signed(out_data_r);

endmodule

### rtl/core/phasing_ssb_dual_fir_demod.sv
// ----------------------------------------------------------------------------
// phasing_ssb_dual_fir_demod
// Phasing SSB demodulator: two FIR lanes (I and Q) against two coefficient
// banks, merged into one saturated slot word.
// ----------------------------------------------------------------------------
// A coefficient transaction (opcode 1) writes one entry of the minus or plus
// bank; load every tap of both banks before the first audio transaction. An
// audio transaction (opcode 0) occupies the block until its sum has moved
// into the output register: each lane reads one history entry from its
// history memory and does one multiply-accumulate per cycle, followed by a
// short multiplier, merge and rounding pipeline. Results wait in an output
// register, so the next transaction is taken while one is still
// undelivered. Writing the sideband register empties both delay lines at
// once through a fill count; no clearing pass runs after reset.
module phasing_ssb_dual_fir_demod (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_sideband,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_opcode,
  input  logic signed [ssbd_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [ssbd_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                                 in_coef_bank,
  input  logic [ssbd_pkg::CTAP_W-1:0]          in_coef_tap,
  input  logic signed [ssbd_pkg::COEF_W-1:0]   in_coef_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ssbd_pkg::OUT_W-1:0]    out_audio_out
);
  import ssbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               sideband_r;
  logic [TAP_W-1:0]   wp_r, wp_inc;
  logic [TAP_W-1:0]   rp_r;
  logic [TAP_W-1:0]   k_r;
  logic [FILL_W-1:0]  fill_r;
  logic               s1_v_r, s1_ok_r, s1_last_r;
  logic               s2_v_r, s2_last_r;
  logic               s3_v_r;
  logic               in_fire, cfg_fire, smp_fire, coef_fire, coef_in_range;
  logic               issue, issue_last;
  logic               merge_busy;
  logic [COEF_W-1:0]  minus_q, plus_q, coef_left, coef_right;
  ssbd_lane_ctl_t     lane_ctl;
  logic signed [ACC_W-1:0] acc_left, acc_right;

  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign smp_fire      = in_fire && (in_opcode == OP_SAMPLE);
  assign coef_in_range = (32'(in_coef_tap) < TAP_COUNT);
  assign coef_fire     = in_fire && (in_opcode == OP_COEF) && coef_in_range;
  assign wp_inc        = (wp_r == TAP_W'(TAP_COUNT - 1)) ? '0 : wp_r + 1'b1;
  assign issue         = (state_r == ST_RUN);
  assign issue_last    = (k_r == TAP_W'(TAP_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (smp_fire) state_nxt = ST_RUN;
      ST_RUN:  if (issue_last) state_nxt = ST_WAIT;
      ST_WAIT: begin
        // hold until the pipeline has drained and the merge has moved its sum to the output register
        if (!s1_v_r && !s2_v_r && !s3_v_r && !merge_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sideband_r <= SB_LSB;
      wp_r       <= '0;
      rp_r       <= '0;
      k_r        <= '0;
      fill_r     <= '0;
      s1_v_r     <= 1'b0;
      s1_ok_r    <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_last_r  <= 1'b0;
      s3_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        sideband_r <= cfg_sideband;
        fill_r     <= '0;
      end else if (smp_fire && (fill_r != FILL_W'(TAP_COUNT))) begin
        fill_r <= fill_r + 1'b1;
      end
      if (smp_fire) begin
        wp_r <= wp_inc;
        rp_r <= wp_inc;
        k_r  <= '0;
      end else if (issue) begin
        // advance one tap back in time
        rp_r <= (rp_r == '0) ? TAP_W'(TAP_COUNT - 1) : rp_r - 1'b1;
        k_r  <= issue_last ? '0 : k_r + 1'b1;
      end
      s1_v_r    <= issue;
      s1_ok_r   <= issue && (FILL_W'(k_r) < fill_r);
      s1_last_r <= issue && issue_last;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_v_r && s1_last_r;
      s3_v_r    <= s2_v_r && s2_last_r;
    end
  end

  ssbd_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAP_COUNT)
  ) u_minus_bank (
    .clk   (clk),
    .we    (coef_fire && (in_coef_bank == BANK_MINUS)),
    .waddr (TAP_W'(in_coef_tap)),
    .wdata (in_coef_value),
    .raddr (k_r),
    .rdata (minus_q)
  );

  ssbd_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAP_COUNT)
  ) u_plus_bank (
    .clk   (clk),
    .we    (coef_fire && (in_coef_bank == BANK_PLUS)),
    .waddr (TAP_W'(in_coef_tap)),
    .wdata (in_coef_value),
    .raddr (k_r),
    .rdata (plus_q)
  );

  assign coef_left  = (sideband_r == SB_LSB) ? minus_q : plus_q;
  assign coef_right = (sideband_r == SB_LSB) ? plus_q : minus_q;

  assign lane_ctl = '{acc_clr: smp_fire, mul_en: s1_v_r, mul_ok: s1_ok_r,
                      acc_en: s2_v_r};

  ssbd_lane u_lane_left (
    .clk        (clk),
    .hist_we    (smp_fire),
    .hist_waddr (wp_inc),
    .hist_wdata (in_left_sample),
    .hist_raddr (rp_r),
    .coef       (coef_left),
    .ctl        (lane_ctl),
    .acc        (acc_left)
  );

  ssbd_lane u_lane_right (
    .clk        (clk),
    .hist_we    (smp_fire),
    .hist_waddr (wp_inc),
    .hist_wdata (in_right_sample),
    .hist_raddr (rp_r),
    .coef       (coef_right),
    .ctl        (lane_ctl),
    .acc        (acc_right)
  );

  ssbd_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .sum_en        (s3_v_r),
    .acc_left      (acc_left),
    .acc_right     (acc_right),
    .busy          (merge_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_audio_out (out_audio_out)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TAP_COUNT))
    else $error("history fill count beyond depth");

  a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    smp_fire |=> (state_r == ST_RUN) && (k_r == '0))
    else $error("sample transaction did not start the tap sweep at tap 0");

  a_merge_free: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> !merge_busy)
    else $error("new lane sum arrived while merge still holds one");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r || s3_v_r) |-> !in_ready)
    else $error("input taken while the lanes are still accumulating");

endmodule

### test/phasing_ssb_dual_fir_demod_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phasing_ssb_dual_fir_demod_tb
// Drives coefficient and audio transactions into the demodulator and checks
// each audio result against an in-bench model of the two FIR lanes. The
// model covers both sidebands, history clearing on sideband writes,
// truncation toward zero and saturation. Traffic runs under several
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module phasing_ssb_dual_fir_demod_tb;
  import ssbd_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 175;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = 24'sh800000;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] left_word;
    logic signed [SAMPLE_W-1:0] right_word;
    logic                       bank;
    logic [CTAP_W-1:0]          tap;
    logic signed [COEF_W-1:0]   coef;
  } demod_item_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_sideband = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_opcode = 1'b0;
  logic signed [SAMPLE_W-1:0] in_left_sample = '0;
  logic signed [SAMPLE_W-1:0] in_right_sample = '0;
  logic                       in_coef_bank = 1'b0;
  logic [CTAP_W-1:0]          in_coef_tap = '0;
  logic signed [COEF_W-1:0]   in_coef_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_W-1:0]    out_audio_out;

  phasing_ssb_dual_fir_demod u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sideband    (cfg_sideband),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_coef_bank    (in_coef_bank),
    .in_coef_tap     (in_coef_tap),
    .in_coef_value   (in_coef_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_audio_out   (out_audio_out)
  );

  // Model state
  logic                       sideband_q;
  logic signed [SAMPLE_W-1:0] left_line  [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] right_line [TAP_COUNT];
  logic signed [COEF_W-1:0]   minus_coef [TAP_COUNT];
  logic signed [COEF_W-1:0]   plus_coef  [TAP_COUNT];

  demod_item_t                pending_items [$];
  logic signed [OUT_W-1:0]    expected_audio [$];
  demod_item_t                drv_item;
  int                         queued_items = 0;
  int                         accepted_items = 0;
  int                         mismatch_count = 0;
  int                         idle_cycles = 0;
  int                         send_idle_pct = 0;
  int                         stall_pct = 0;
  logic                       in_fire = 1'b0;
  logic                       cfg_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_lines();
    for (int k = 0; k < TAP_COUNT; k++) begin
      left_line[k]  = '0;
      right_line[k] = '0;
    end
  endfunction

  // Shift one sample pair into both lines, then run both FIRs over them.
  function automatic logic signed [OUT_W-1:0] demod_sample(
    input logic signed [SAMPLE_W-1:0] left_in,
    input logic signed [SAMPLE_W-1:0] right_in
  );
    logic signed [71:0]       dot;
    logic signed [71:0]       quo;
    logic signed [COEF_W-1:0] lc;
    logic signed [COEF_W-1:0] rc;
    for (int k = TAP_COUNT - 1; k > 0; k--) begin
      left_line[k]  = left_line[k-1];
      right_line[k] = right_line[k-1];
    end
    left_line[0]  = left_in;
    right_line[0] = right_in;
    dot = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      lc  = (sideband_q == SB_LSB) ? minus_coef[k] : plus_coef[k];
      rc  = (sideband_q == SB_LSB) ? plus_coef[k] : minus_coef[k];
      dot = dot + left_line[k] * lc + right_line[k] * rc;
    end
    // signed divide truncates toward zero
    quo = dot / 72'sd1048576;
    if (quo > 72'sd2147483647)
      return SAMPLE_MAX;
    else if (quo < -72'sd2147483648)
      return SAMPLE_MIN;
    return quo[OUT_W-1:0];
  endfunction

  function automatic void check_audio(input logic signed [OUT_W-1:0] got);
    logic signed [OUT_W-1:0] want;
    if (expected_audio.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: audio_out %0d arrived with nothing pending", $time, got);
    end else begin
      want = expected_audio.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: audio_out expected %0d, got %0d", $time, want, got);
      end
    end
  endfunction

  // Monitor: track configuration and accepted items, check results
  always @(posedge clk) begin
    in_fire  <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (!rst_n) begin
      sideband_q = SB_LSB;
      clear_lines();
    end else begin
      if (cfg_valid && cfg_ready) begin
        sideband_q = cfg_sideband;
        clear_lines();
      end
      if (out_valid && out_ready)
        check_audio(out_audio_out);
      if (in_valid && in_ready) begin
        accepted_items++;
        if (in_opcode == OP_COEF) begin
          if (in_coef_tap < TAP_COUNT) begin
            if (in_coef_bank == BANK_PLUS)
              plus_coef[in_coef_tap] = in_coef_value;
            else
              minus_coef[in_coef_tap] = in_coef_value;
          end
        end else begin
          expected_audio.push_back(demod_sample(in_left_sample, in_right_sample));
        end
      end
    end
  end

  // Driver: present the next pending item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item        = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_opcode       <= drv_item.op;
          in_left_sample  <= drv_item.left_word;
          in_right_sample <= drv_item.right_word;
          in_coef_bank    <= drv_item.bank;
          in_coef_tap     <= drv_item.tap;
          in_coef_value   <= drv_item.coef;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: no transaction of any kind for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] w;
    w = $urandom;
    w = w >>> $urandom_range(31);
    // drop the pad byte below the 24-bit audio now and then
    if ($urandom_range(3) == 0)
      w[7:0] = 8'h00;
    return w;
  endfunction

  // Mostly modest coefficients so that sums span the unsaturated range
  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    if ($urandom_range(15) != 0)
      c = c >>> $urandom_range(23, 8);
    return c;
  endfunction

  function automatic void push_audio(
    input logic signed [SAMPLE_W-1:0] left_in,
    input logic signed [SAMPLE_W-1:0] right_in
  );
    demod_item_t it;
    it.op         = OP_SAMPLE;
    it.left_word  = left_in;
    it.right_word = right_in;
    it.bank       = 1'($urandom_range(1));
    it.tap        = CTAP_W'($urandom_range(127));
    it.coef       = COEF_W'($urandom);
    pending_items.push_back(it);
    queued_items++;
  endfunction

  function automatic void push_coef(
    input logic                     bank,
    input logic [CTAP_W-1:0]        tap,
    input logic signed [COEF_W-1:0] value
  );
    demod_item_t it;
    it.op         = OP_COEF;
    it.left_word  = $urandom;
    it.right_word = $urandom;
    it.bank       = bank;
    it.tap        = tap;
    it.coef       = value;
    pending_items.push_back(it);
    queued_items++;
  endfunction

  // Wait until every item is taken and every result is back, then let the
  // block finish any trailing work.
  task automatic settle_block();
    do @(negedge clk);
    while (accepted_items != queued_items || expected_audio.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sideband(input logic sb);
    @(negedge clk);
    cfg_sideband <= sb;
    cfg_valid    <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extreme banks, then extreme samples
    write_sideband(SB_USB);
    for (int k = 0; k < TAP_COUNT; k++) begin
      push_coef(BANK_MINUS, CTAP_W'(k), COEF_MAX);
      push_coef(BANK_PLUS, CTAP_W'(k), COEF_MIN);
    end
    push_audio(0, 0);
    push_audio(SAMPLE_MAX, 0);
    push_audio(SAMPLE_MIN, SAMPLE_MIN);
    push_audio(0, SAMPLE_MAX);
    push_audio(1, -1);
    push_audio(-1, 1);
    push_audio(32'sh100, -32'sh100);
    settle_block();

    // Positive saturation from freshly cleared lines
    write_sideband(SB_LSB);
    push_audio(SAMPLE_MAX, 0);
    push_audio(SAMPLE_MIN, SAMPLE_MAX);
    push_coef(BANK_PLUS, '0, -24'sd1);
    push_coef(BANK_MINUS, CTAP_W'(TAP_COUNT - 1), 24'sd0);
    settle_block();

    // Negative quotient that must truncate toward zero
    write_sideband(SB_USB);
    push_audio(SAMPLE_MAX, 0);
    push_audio(0, 32'sh100000);
    settle_block();

    for (int p = 0; p < 8; p++) begin
      if (p != 0)
        write_sideband((p % 2) ? SB_LSB : SB_USB);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 0) begin
        for (int k = 0; k < TAP_COUNT; k++) begin
          push_coef(BANK_MINUS, CTAP_W'(k), rand_coef());
          push_coef(BANK_PLUS, CTAP_W'(k), rand_coef());
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 12)
          push_coef(1'($urandom_range(1)), CTAP_W'($urandom_range(127)), rand_coef());
        else
          push_audio(rand_sample(), rand_sample());
      end
      settle_block();
    end

    if (mismatch_count == 0 && expected_audio.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
